// File: hdl/pb64q_pkg.sv
// Package for the paste base64 / quote encoder.
// Holds the job record passed from front to back, register indexes and the
// base64 alphabet function. No dependencies.
package pb64q_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CHAR_CTRL_V = 8'h16;

	// configuration register indexes
	localparam logic CFG_BASE64 = 1'b0;
	localparam logic CFG_QUOTE  = 1'b1;

	// one byte's worth of output: one or two characters
	typedef struct packed {
		logic [7:0] char0;
		logic [7:0] char1;
		logic       two;
		logic       endf;
		logic [1:0] cnt0;
		logic [1:0] cnt1;
	} pb64q_job_t;

	// standard alphabet: A-Z a-z 0-9 + /
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) return w + 8'd65;
		else if (v < 6'd52) return w + 8'd71;
		else if (v < 6'd62) return w - 8'd4;
		else if (v == 6'd62) return 8'd43;
		else return 8'd47;
	endfunction

endpackage

// File: hdl/pb64q_front.sv
// Front end: mode registers, base64 group state and per-byte job build.
// Depends on pb64q_pkg.
module pb64q_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic               cfg_data,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               paste_end,
	output pb64q_pkg::pb64q_job_t job
);
	import pb64q_pkg::*;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_ONE   = 2'd1;
	localparam logic [1:0] PH_TWO   = 2'd2;

	logic       b64_q, quote_q;
	logic [1:0] phase_q, nxt_phase;
	logic [3:0] held_q, nxt_held;
	logic [1:0] cnt_q, nxt_cnt;
	logic [1:0] inc1, inc2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b64_q   <= 1'b0;
			quote_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE64: b64_q   <= cfg_data;
				CFG_QUOTE:  quote_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign inc1 = cnt_q + 2'd1;
	assign inc2 = cnt_q + 2'd2;

	always_comb begin
		job.char0 = data_byte;
		job.char1 = data_byte;
		job.two   = 1'b0;
		job.endf  = paste_end;
		job.cnt0  = cnt_q;
		job.cnt1  = cnt_q;
		nxt_phase = phase_q;
		nxt_held  = held_q;
		nxt_cnt   = cnt_q;
		if (b64_q) begin
			unique case (phase_q)
				PH_ONE: begin
					job.char0 = sextet_char({held_q[1:0], data_byte[7:4]});
					job.cnt0  = inc1;
					nxt_cnt   = inc1;
					nxt_held  = data_byte[3:0];
					nxt_phase = PH_TWO;
				end
				PH_TWO: begin
					job.char0 = sextet_char({held_q, data_byte[7:6]});
					job.char1 = sextet_char(data_byte[5:0]);
					job.two   = 1'b1;
					job.cnt0  = inc1;
					job.cnt1  = inc2;
					nxt_cnt   = inc2;
					nxt_held  = 4'd0;
					nxt_phase = PH_START;
				end
				default: begin  // start of group; unused code behaves the same
					job.char0 = sextet_char(data_byte[7:2]);
					job.cnt0  = inc1;
					nxt_cnt   = inc1;
					nxt_held  = {2'b00, data_byte[1:0]};
					nxt_phase = PH_ONE;
				end
			endcase
		end else if (quote_q) begin
			job.char0 = CHAR_CTRL_V;
			job.two   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			held_q  <= 4'd0;
			cnt_q   <= 2'd0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			held_q  <= nxt_held;
			cnt_q   <= nxt_cnt;
		end
	end

endmodule

// File: hdl/pb64q_queue.sv
// Short job queue between front and back ends.
// Depends on pb64q_pkg.
module pb64q_queue #(
	parameter int DEPTH = pb64q_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pb64q_pkg::pb64q_job_t  push_job,
	output logic                   full,
	input  logic                   pop,
	output logic                   nonempty,
	output pb64q_pkg::pb64q_job_t  head_job
);
	import pb64q_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pb64q_job_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hdl/pb64q_back.sv
// Back end: walks each queued job one character per beat into the
// output register. Depends on pb64q_pkg.
module pb64q_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  pb64q_pkg::pb64q_job_t job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_char,
	output logic                  last_of_run,
	output logic                  end_flag,
	output logic [1:0]            emitted_mod4
);
	import pb64q_pkg::*;

	logic       valid_q, second_q, load;
	logic [7:0] char_q;
	logic       last_q, endf_q;
	logic [1:0] cnt_q;

	assign load = job_valid && (!valid_q || !out_stall);
	assign pop  = load && (second_q || !job.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= !second_q && job.two;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= second_q ? job.char1 : job.char0;
			cnt_q  <= second_q ? job.cnt1 : job.cnt0;
			last_q <= second_q || !job.two;
			endf_q <= (second_q || !job.two) && job.endf;
		end
	end

	assign out_valid    = valid_q;
	assign out_char     = char_q;
	assign last_of_run  = last_q;
	assign end_flag     = endf_q;
	assign emitted_mod4 = cnt_q;

endmodule

// File: hdl/paste_base64_quote_encoder_unit.sv
// Top level of the paste encoder: front end, job queue, back end.
// Depends on pb64q_pkg, pb64q_front, pb64q_queue and pb64q_back.
//
// Usage:
//  Input channel (in_valid / in_stall): one pasted byte per beat with its
//  paste_end mark. Output channel (out_valid / out_stall): one terminal
//  character per beat, with last_of_run on the final character of a byte,
//  end_flag copying paste_end there, and emitted_mod4 giving the base64
//  character count so far modulo 4 (unchanged in the other modes).
//  Config: cfg_we writes cfg_data into register cfg_index (0 base64_mode,
//  1 quote_mode); write only while the block is idle.
//  Modes: base64 emits one character per byte, two on the third byte of a
//  group; quote emits Control-V then the byte; pass-through emits the byte.
//  Path: an accepted byte's job is written into the job queue; its first
//  character is then loaded into the output register. Throughput is one
//  character per cycle while out_stall is low, set by the single output
//  register, so each character of a two character result takes its own beat.
//  in_stall rises only when the job queue (QUEUE_DEPTH entries) is full, so
//  a stalled receiver backs up the queue before the input side stalls.
//  Reset clears the modes, the base64 group state and count, and the queue.
module paste_base64_quote_encoder_unit #(
	parameter int QUEUE_DEPTH = pb64q_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       paste_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       end_flag,
	output logic [1:0] emitted_mod4
);
	import pb64q_pkg::*;

	pb64q_job_t new_job, head_job;
	logic       accept, q_full, q_nonempty, q_pop;

	// a byte is taken whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	pb64q_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (data_byte),
		.paste_end (paste_end),
		.job       (new_job)
	);

	pb64q_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (new_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head_job (head_job)
	);

	// back end splits two-character jobs over two beats
	pb64q_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_nonempty),
		.job          (head_job),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.end_flag     (end_flag),
		.emitted_mod4 (emitted_mod4)
	);

endmodule
